@@ src/incdf_pkg.sv @@
// ============================================================================
// incdf_pkg: shared constants and types for the inverse normal CDF block
// Holds the fixed-point widths, the rational approximation coefficients and
// the sideband tag type used by the pipeline modules.
// ============================================================================
`default_nettype none

package incdf_pkg;

    // Default parameter values.
    localparam int PROB_FRAC_BITS_DEF   = 32;
    localparam int RESULT_FRAC_BITS_DEF = 16;

    // Internal fixed-point formats.
    localparam int INT_FRAC  = 28;
    localparam int MANT_FRAC = 30;
    localparam int LOG_ITERS = 30;
    localparam int W_M       = 32;   // Q1.30 mantissa, fits below 2^32
    localparam int W_L       = 37;   // -log2 q in Q.30, up to 48 * 2^30
    localparam int W_U       = 38;   // -2 ln q in Q.30, up to 67 * 2^30
    localparam int W_T       = 32;   // sqrt in Q.28
    localparam int W_RAD     = W_U + 26;
    localparam int SQRT_ITERS = W_RAD / 2;
    localparam int W_ACC     = 40;   // Horner accumulators
    localparam int W_QUO     = 40;
    localparam int W_NUMSH   = W_ACC + INT_FRAC + 1;

    localparam logic [W_ACC-1:0] C0 = W_ACC'(64'd675253953);
    localparam logic [W_ACC-1:0] C1 = W_ACC'(64'd215514211);
    localparam logic [W_ACC-1:0] C2 = W_ACC'(64'd2772401);
    localparam logic [W_ACC-1:0] D0 = W_ACC'(64'd384611100);
    localparam logic [W_ACC-1:0] D1 = W_ACC'(64'd50806510);
    localparam logic [W_ACC-1:0] D2 = W_ACC'(64'd351114);
    localparam logic [W_ACC-1:0] ONE_Q28 = W_ACC'(64'd268435456);
    localparam logic [24:0] TWO_LN2_Q24 = 25'd23258160;

    // Sideband that travels with every item.
    typedef struct packed {
        logic valid;
        logic invalid;
        logic lower;
    } t_tag;

endpackage

`default_nettype wire

@@ src/incdf_log.sv @@
// ============================================================================
// incdf_log: fold, normalize and take -2 ln q
// Folds p about one half, normalizes q, forms log2 of the mantissa one
// squaring per stage, and scales the result to -2 ln q in Q.30.
// ============================================================================
`default_nettype none

module incdf_log #(
    parameter int PROB_FRAC_BITS = incdf_pkg::PROB_FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [PROB_FRAC_BITS-1:0]     i_prob,
    output incdf_pkg::t_tag              o_tag,
    output logic [incdf_pkg::W_U-1:0]    o_u
);
    import incdf_pkg::*;

    localparam int PF = PROB_FRAC_BITS;
    localparam int KW = $clog2(PF + 1);
    localparam int NS = LOG_ITERS + 1;

    // Front stage: fold and normalize.
    logic [PF:0]   w_q;
    logic [KW-1:0] w_k;
    logic [W_M-1:0] w_m;
    logic          w_lower;

    always_comb begin
        w_lower = (i_prob[PF-1] == 1'b0);
        w_q     = w_lower ? {1'b0, i_prob} : ((PF+1)'(1) << PF) - {1'b0, i_prob};
        w_k     = '0;
        for (int i = 0; i <= PF; i++) begin
            if (w_q[i]) w_k = KW'(i);
        end
        if (w_k >= KW'(MANT_FRAC)) begin
            w_m = W_M'(w_q >> (w_k - KW'(MANT_FRAC)));
        end else begin
            w_m = W_M'(w_q) << (KW'(MANT_FRAC) - w_k);
        end
    end

    // Squaring chain registers: stage 0 holds the normalized mantissa.
    t_tag            r_tag [NS];
    logic [W_M-1:0]  r_m   [NS];
    logic [LOG_ITERS-1:0] r_lf [NS];
    logic [KW-1:0]   r_k   [NS];

    // One squaring per stage; only the valid bits are reset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0].invalid <= (i_prob == '0);
            r_tag[0].lower   <= w_lower;
            r_m[0]  <= w_m;
            r_lf[0] <= '0;
            r_k[0]  <= w_k;
            for (int s = 1; s < NS; s++) begin
                logic [2*W_M-1:0] sq;
                logic [W_M-1:0]   ms;
                sq = r_m[s-1] * r_m[s-1];
                ms = W_M'(sq >> MANT_FRAC);
                r_tag[s].invalid <= r_tag[s-1].invalid;
                r_tag[s].lower   <= r_tag[s-1].lower;
                r_k[s] <= r_k[s-1];
                if (ms[31]) begin
                    r_m[s]  <= ms >> 1;
                    r_lf[s] <= {r_lf[s-1][LOG_ITERS-2:0], 1'b1};
                end else begin
                    r_m[s]  <= ms;
                    r_lf[s] <= {r_lf[s-1][LOG_ITERS-2:0], 1'b0};
                end
            end
        end
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_tag[s].valid <= 1'b0;
        end else if (i_en) begin
            r_tag[0].valid <= i_valid;
            for (int s = 1; s < NS; s++) r_tag[s].valid <= r_tag[s-1].valid;
        end
    end

    // Scale -log2 q to -2 ln q.
    logic [W_L-1:0] w_l;
    logic [W_L+25-1:0] w_prod;
    logic [W_L-1:0] r_l;
    t_tag r_tagl;
    logic [W_L+25-1:0] r_prod;
    t_tag r_tagp;

    assign w_l = (W_L'(KW'(PF) - r_k[NS-1]) << MANT_FRAC) - W_L'(r_lf[NS-1]);
    assign w_prod = W_L'(r_l) * TWO_LN2_Q24;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l <= w_l;
            r_tagl.invalid <= r_tag[NS-1].invalid;
            r_tagl.lower   <= r_tag[NS-1].lower;
            r_prod <= w_prod + (W_L+25)'(1 << 23);
            r_tagp.invalid <= r_tagl.invalid;
            r_tagp.lower   <= r_tagl.lower;
        end
        if (!i_rst_n) begin
            r_tagl.valid <= 1'b0;
            r_tagp.valid <= 1'b0;
        end else if (i_en) begin
            r_tagl.valid <= r_tag[NS-1].valid;
            r_tagp.valid <= r_tagl.valid;
        end
    end

    assign o_tag = r_tagp;
    assign o_u   = W_U'(r_prod >> 24);

endmodule

`default_nettype wire

@@ src/incdf_sqrt.sv @@
// ============================================================================
// incdf_sqrt: pipelined integer square root
// Restoring square root of u * 2^26, one result bit per stage, giving t in
// Q.28.
// ============================================================================
`default_nettype none

module incdf_sqrt (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  incdf_pkg::t_tag            i_tag,
    input  wire [incdf_pkg::W_U-1:0]   i_u,
    output incdf_pkg::t_tag            o_tag,
    output logic [incdf_pkg::W_T-1:0]  o_t
);
    import incdf_pkg::*;

    localparam int NS = SQRT_ITERS + 1;
    localparam int WR = SQRT_ITERS + 2;

    t_tag              r_tag [NS];
    logic [W_RAD-1:0]  r_rad [NS];
    logic [WR-1:0]     r_rem [NS];
    logic [SQRT_ITERS-1:0] r_root [NS];

    // Each stage brings down two radicand bits and decides one root bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0].invalid <= i_tag.invalid;
            r_tag[0].lower   <= i_tag.lower;
            r_rad[0]  <= {i_u, 26'd0};
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int s = 1; s < NS; s++) begin
                logic [WR-1:0] trial;
                logic [WR-1:0] cur;
                cur   = {r_rem[s-1][WR-3:0], r_rad[s-1][W_RAD-1 -: 2]};
                trial = {r_root[s-1], 2'b01};
                r_tag[s].invalid <= r_tag[s-1].invalid;
                r_tag[s].lower   <= r_tag[s-1].lower;
                r_rad[s] <= r_rad[s-1] << 2;
                if (cur >= trial) begin
                    r_rem[s]  <= cur - trial;
                    r_root[s] <= {r_root[s-1][SQRT_ITERS-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= cur;
                    r_root[s] <= {r_root[s-1][SQRT_ITERS-2:0], 1'b0};
                end
            end
        end
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_tag[s].valid <= 1'b0;
        end else if (i_en) begin
            r_tag[0].valid <= i_tag.valid;
            for (int s = 1; s < NS; s++) r_tag[s].valid <= r_tag[s-1].valid;
        end
    end

    assign o_tag = r_tag[NS-1];
    assign o_t   = W_T'(r_root[NS-1]);

endmodule

`default_nettype wire

@@ src/incdf_ratio.sv @@
// ============================================================================
// incdf_ratio: rational correction and output rounding
// Evaluates both polynomials by Horner's rule one step per stage, divides
// them with a pipelined restoring divider, and rounds to the output format.
// ============================================================================
`default_nettype none

module incdf_ratio #(
    parameter int RESULT_FRAC_BITS = incdf_pkg::RESULT_FRAC_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  incdf_pkg::t_tag               i_tag,
    input  wire [incdf_pkg::W_T-1:0]      i_t,
    output incdf_pkg::t_tag               o_tag,
    output logic [RESULT_FRAC_BITS+4:0]   o_quantile
);
    import incdf_pkg::*;

    localparam int QW  = RESULT_FRAC_BITS + 5;
    localparam int NH  = 3;              // Horner stages
    localparam int ND  = W_QUO;          // divider stages
    localparam int WDR = W_ACC + 2;

    // Horner pipeline: stage h holds den after h steps; num stops after two steps and is held.
    t_tag             r_htag [NH+1];
    logic [W_T-1:0]   r_ht   [NH+1];
    logic [W_ACC-1:0] r_num  [NH+1];
    logic [W_ACC-1:0] r_den  [NH+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_htag[0].invalid <= i_tag.invalid;
            r_htag[0].lower   <= i_tag.lower;
            r_ht[0]  <= i_t;
            r_num[0] <= C2;
            r_den[0] <= D2;
            for (int s = 1; s <= NH; s++) begin
                logic [W_ACC+W_T-1:0] pn;
                logic [W_ACC+W_T-1:0] pd;
                logic [W_ACC-1:0] kn;
                logic [W_ACC-1:0] kd;
                pn = r_num[s-1] * r_ht[s-1];
                pd = r_den[s-1] * r_ht[s-1];
                kn = (s == 1) ? C1 : C0;
                kd = (s == 1) ? D1 : ((s == 2) ? D0 : ONE_Q28);
                r_htag[s].invalid <= r_htag[s-1].invalid;
                r_htag[s].lower   <= r_htag[s-1].lower;
                r_ht[s]  <= r_ht[s-1];
                r_num[s] <= (s == NH) ? r_num[s-1] : W_ACC'(pn >> INT_FRAC) + kn;
                r_den[s] <= W_ACC'(pd >> INT_FRAC) + kd;
            end
        end
        if (!i_rst_n) begin
            for (int s = 0; s <= NH; s++) r_htag[s].valid <= 1'b0;
        end else if (i_en) begin
            r_htag[0].valid <= i_tag.valid;
            for (int s = 1; s <= NH; s++) r_htag[s].valid <= r_htag[s-1].valid;
        end
    end

    // Restoring divider: (num << 28) + den/2 over den, one quotient bit per stage.
    t_tag               r_dtag [ND+1];
    logic [W_T-1:0]     r_dt   [ND+1];
    logic [W_ACC-1:0]   r_dden [ND+1];
    logic [W_QUO-1:0]   r_dnum [ND+1];
    logic [WDR-1:0]     r_drem [ND+1];
    logic [W_QUO-1:0]   r_quo  [ND+1];

    logic [W_NUMSH-1:0] w_dividend;
    assign w_dividend = (W_NUMSH'(r_num[NH]) << INT_FRAC) + W_NUMSH'(r_den[NH] >> 1);

    // The quotient fits in W_QUO bits, so the upper dividend bits seed the remainder.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dtag[0].invalid <= r_htag[NH].invalid;
            r_dtag[0].lower   <= r_htag[NH].lower;
            r_dt[0]   <= r_ht[NH];
            r_dden[0] <= r_den[NH];
            r_dnum[0] <= w_dividend[W_QUO-1:0];
            r_drem[0] <= WDR'(w_dividend >> W_QUO);
            r_quo[0]  <= '0;
            for (int s = 1; s <= ND; s++) begin
                logic [WDR-1:0] cur;
                cur = {r_drem[s-1][WDR-2:0], r_dnum[s-1][W_QUO-1]};
                r_dtag[s].invalid <= r_dtag[s-1].invalid;
                r_dtag[s].lower   <= r_dtag[s-1].lower;
                r_dt[s]   <= r_dt[s-1];
                r_dden[s] <= r_dden[s-1];
                r_dnum[s] <= r_dnum[s-1] << 1;
                if (cur >= WDR'(r_dden[s-1])) begin
                    r_drem[s] <= cur - WDR'(r_dden[s-1]);
                    r_quo[s]  <= {r_quo[s-1][W_QUO-2:0], 1'b1};
                end else begin
                    r_drem[s] <= cur;
                    r_quo[s]  <= {r_quo[s-1][W_QUO-2:0], 1'b0};
                end
            end
        end
        if (!i_rst_n) begin
            for (int s = 0; s <= ND; s++) r_dtag[s].valid <= 1'b0;
        end else if (i_en) begin
            r_dtag[0].valid <= r_htag[NH].valid;
            for (int s = 1; s <= ND; s++) r_dtag[s].valid <= r_dtag[s-1].valid;
        end
    end

    // Difference, sign and rounding to the output format.
    localparam int WMAG = W_QUO + 33;
    logic [W_QUO-1:0] w_t;
    logic [W_QUO-1:0] w_diff;
    logic             w_neg;
    logic [WMAG-1:0]  w_mag;
    logic [QW-1:0]    w_res;
    localparam logic [WMAG-1:0] MAXMAG = WMAG'((64'd1 << (QW - 1)) - 64'd1);

    always_comb begin
        w_t = W_QUO'(r_dt[ND]);
        if (w_t >= r_quo[ND]) begin
            w_diff = w_t - r_quo[ND];
            w_neg  = r_dtag[ND].lower;
        end else begin
            w_diff = r_quo[ND] - w_t;
            w_neg  = !r_dtag[ND].lower;
        end
        if (RESULT_FRAC_BITS < INT_FRAC) begin
            w_mag = (WMAG'(w_diff) + (WMAG'(1) << (INT_FRAC - RESULT_FRAC_BITS - 1)))
                    >> (INT_FRAC - RESULT_FRAC_BITS);
        end else begin
            w_mag = WMAG'(w_diff) << (RESULT_FRAC_BITS - INT_FRAC);
        end
        if (w_mag > MAXMAG) w_mag = MAXMAG;
        w_res = w_neg ? QW'(-w_mag) : QW'(w_mag);
        if (r_dtag[ND].invalid) w_res = '0;
    end

    t_tag          r_otag;
    logic [QW-1:0] r_oq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_otag.invalid <= r_dtag[ND].invalid;
            r_otag.lower   <= r_dtag[ND].lower;
            r_oq <= w_res;
        end
        if (!i_rst_n) begin
            r_otag.valid <= 1'b0;
        end else if (i_en) begin
            r_otag.valid <= r_dtag[ND].valid;
        end
    end

    assign o_tag      = r_otag;
    assign o_quantile = r_oq;

endmodule

`default_nettype wire

@@ src/inverse_normal_cdf_top.sv @@
// ============================================================================
// inverse_normal_cdf_top: streaming standard normal quantile
// Pipelined Abramowitz-Stegun 26.2.23 approximation from Q0.32 to Q4.16.
// ============================================================================
// Usage:
// The slave channel takes one probability per transaction on s_axis_tdata.
// The master channel returns the quantile and an invalid flag for each one,
// in order. A zero probability gives invalid = 1 and a zero quantile.
// Throughput is one transaction per cycle unless the receiver stalls. A
// result passes 112 register stages on its way from input to output:
// 31 log squaring stages, 2 scaling stages, 33 square root stages,
// 4 Horner stages, 41 divider stages and one output register; the
// divider is the longest part.
// The whole pipeline advances only when its output register is empty or
// being taken, so when the receiver stalls every stage holds and nothing
// is lost or repeated; s_axis_tready falls only while a result waits.
// Synchronous reset clears all valid bits; the payload is left as is.
// The block keeps no state between transactions.
`default_nettype none

module inverse_normal_cdf_top #(
    parameter int PROB_FRAC_BITS   = incdf_pkg::PROB_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = incdf_pkg::RESULT_FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [PROB_FRAC_BITS-1:0] prob_fraction, zero filled to whole bytes
    input  wire [((PROB_FRAC_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [RESULT_FRAC_BITS+4:0] quantile, zero filled to whole bytes
    output logic [((RESULT_FRAC_BITS+12)/8)*8-1:0] m_axis_tdata,
    // [0] invalid
    output logic                                 m_axis_tuser
);
    import incdf_pkg::*;

    localparam int QW  = RESULT_FRAC_BITS + 5;
    localparam int ODW = ((RESULT_FRAC_BITS + 12) / 8) * 8;

    logic w_en;
    t_tag w_ltag, w_stag, w_otag;
    logic [W_U-1:0] w_u;
    logic [W_T-1:0] w_t;
    logic [QW-1:0]  w_q;

    // Global advance: the output register is free or is being read.
    assign w_en = !w_otag.valid || m_axis_tready;
    assign s_axis_tready = w_en;

    incdf_log #(.PROB_FRAC_BITS(PROB_FRAC_BITS)) u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(s_axis_tvalid),
        .i_prob(s_axis_tdata[PROB_FRAC_BITS-1:0]),
        .o_tag(w_ltag), .o_u(w_u)
    );

    incdf_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_tag(w_ltag), .i_u(w_u), .o_tag(w_stag), .o_t(w_t)
    );

    incdf_ratio #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_ratio (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_tag(w_stag), .i_t(w_t), .o_tag(w_otag), .o_quantile(w_q)
    );

    assign m_axis_tvalid = w_otag.valid;
    assign m_axis_tdata  = ODW'(w_q);
    assign m_axis_tuser  = w_otag.invalid;

`ifndef SYNTHESIS
    // A waiting result holds its payload while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // The input is blocked only while a result waits and is not taken.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without a stall");
    // An invalid result always carries a zero quantile.
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid flag with nonzero quantile");
`endif

endmodule

`default_nettype wire
